// ----- hdl/session_handshake_rtt_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Session engine assertion macros
// Shared property forms for the session engine checkers.
// ----------------------------------------------------------------------------
`ifndef SESSION_HANDSHAKE_RTT_ENGINE_DEFINES_SVH
`define SESSION_HANDSHAKE_RTT_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHRE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define SHRE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- hdl/shre_pkg.sv -----
// ----------------------------------------------------------------------------
// Session engine package
// Codes, register map and the structs shared by the session engine modules.
// ----------------------------------------------------------------------------
package shre_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        REG_INITIATOR  = 2'd0,
        REG_LOCAL_ID   = 2'd1,
        REG_MAX_RETRY  = 2'd2,
        REG_RETRY_BASE = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        CMD_START      = 4'd0,
        CMD_RETRY_EXP  = 4'd1,
        CMD_HBEAT_EXP  = 4'd2,
        CMD_STOP       = 4'd3,
        CMD_RX_CONN    = 4'd4,
        CMD_RX_CONNACK = 4'd5,
        CMD_RX_PING    = 4'd6,
        CMD_RX_PONG    = 4'd7,
        CMD_RX_DISC    = 4'd8,
        CMD_RX_DISCACK = 4'd9
    } cmd_t;

    typedef enum logic [2:0] {
        SEND_NONE     = 3'd0,
        SEND_CONN     = 3'd1,
        SEND_CONNACK  = 3'd2,
        SEND_PING     = 3'd3,
        SEND_PONG     = 3'd4,
        SEND_DISC     = 3'd5,
        SEND_DISCACK  = 3'd6
    } send_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_CONNECTING   = 2'd1,
        PH_CONNECTED    = 2'd2,
        PH_DISCONNECTED = 2'd3
    } phase_t;

    localparam logic [2:0]  MAX_RETRY_RST  = 3'd3;
    localparam logic [15:0] RETRY_BASE_RST = 16'd100;
    localparam logic [31:0] RTT_RST        = 32'd100;
    localparam logic [31:0] DEV_RST        = 32'd5;
    localparam logic [31:0] SAMPLE_FLOOR   = 32'd5;
    localparam logic [31:0] EST_FLOOR      = 32'd10;

    typedef struct packed {
        logic        initiator;
        logic [31:0] local_conn_id;
        logic [2:0]  max_retries;
        logic [15:0] retry_base_ms;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  attempts_left;
        logic [31:0] smoothed_rtt;
        logic [31:0] smoothed_dev;
        logic        awaiting_first_sample;
        logic        peer_session_active;
    } state_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] now_ms;
        logic [31:0] msg_stamp;
        logic [31:0] msg_conn_id;
    } item_t;

    typedef struct packed {
        send_kind_t  send_kind;
        logic [31:0] send_conn_id;
        logic [31:0] send_stamp;
        logic [21:0] retry_delay;
        logic        cancel_retry;
        logic [33:0] heartbeat_delay;
        logic        cancel_heartbeat;
        phase_t      session_state;
        logic        connected_event;
        logic        failed_event;
        logic [31:0] rtt_estimate;
        logic [31:0] rtt_deviation;
    } result_t;

endpackage

// ----- hdl/shre_if.sv -----
// ----------------------------------------------------------------------------
// Session engine channels
// Valid/ready channels for event beats and result beats.
// ----------------------------------------------------------------------------
interface shre_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [31:0] now_ms;
    logic [31:0] msg_stamp;
    logic [31:0] msg_conn_id;

    modport source (
        output valid, command, now_ms, msg_stamp, msg_conn_id,
        input  ready
    );
    modport sink (
        input  valid, command, now_ms, msg_stamp, msg_conn_id,
        output ready
    );
endinterface

interface shre_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  send_kind;
    logic [31:0] send_conn_id;
    logic [31:0] send_stamp;
    logic [21:0] retry_delay;
    logic        cancel_retry;
    logic [33:0] heartbeat_delay;
    logic        cancel_heartbeat;
    logic [1:0]  session_state;
    logic        connected_event;
    logic        failed_event;
    logic [31:0] rtt_estimate;
    logic [31:0] rtt_deviation;

    modport source (
        output valid, send_kind, send_conn_id, send_stamp, retry_delay, cancel_retry,
               heartbeat_delay, cancel_heartbeat, session_state, connected_event,
               failed_event, rtt_estimate, rtt_deviation,
        input  ready
    );
    modport sink (
        input  valid, send_kind, send_conn_id, send_stamp, retry_delay, cancel_retry,
               heartbeat_delay, cancel_heartbeat, session_state, connected_event,
               failed_event, rtt_estimate, rtt_deviation,
        output ready
    );
endinterface

// ----- hdl/session_handshake_rtt_engine.sv -----
// ----------------------------------------------------------------------------
// Session handshake and RTT engine
// Connect handshake with backoff, keepalive and smoothed RTT, one event a beat.
// ----------------------------------------------------------------------------
// Takes one event beat per clock while the result side takes beats and returns
// exactly one result beat for each, in order. An event lands in an input
// register, then the step logic updates the session state and fills the
// result register, where a result waits while the result side stalls.
// The user must write configuration over the APB port only while no event
// is in flight; the block itself does not enforce this.
module session_handshake_rtt_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    shre_evt_if.sink                        evt,
    shre_res_if.source                      res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [shre_pkg::ADDR_W-1:0]     paddr,
    input  logic [shre_pkg::DATA_W-1:0]     pwdata,
    output logic [shre_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    shre_pkg::cfg_t    cfg_reg;
    shre_pkg::state_t  st_reg;
    shre_pkg::state_t  st_next;
    shre_pkg::item_t   item_reg;
    shre_pkg::result_t res_reg;
    shre_pkg::result_t res_next;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              cfg_wr;
    shre_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = shre_pkg::reg_idx_t'(paddr[3:2]);

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;

    shre_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .result  (res_next)
    );

    always_comb
    begin
        unique case (cfg_idx)
            shre_pkg::REG_INITIATOR:  prdata = {31'd0, cfg_reg.initiator};
            shre_pkg::REG_LOCAL_ID:   prdata = cfg_reg.local_conn_id;
            shre_pkg::REG_MAX_RETRY:  prdata = {29'd0, cfg_reg.max_retries};
            shre_pkg::REG_RETRY_BASE: prdata = {16'd0, cfg_reg.retry_base_ms};
            default:                  prdata = '0;
        endcase
    end

    // config and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initiator             <= 1'b0;
            cfg_reg.local_conn_id         <= '0;
            cfg_reg.max_retries           <= shre_pkg::MAX_RETRY_RST;
            cfg_reg.retry_base_ms         <= shre_pkg::RETRY_BASE_RST;
            st_reg.phase                  <= shre_pkg::PH_IDLE;
            st_reg.attempts_left          <= shre_pkg::MAX_RETRY_RST;
            st_reg.smoothed_rtt           <= shre_pkg::RTT_RST;
            st_reg.smoothed_dev           <= shre_pkg::DEV_RST;
            st_reg.awaiting_first_sample  <= 1'b1;
            st_reg.peer_session_active    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    shre_pkg::REG_INITIATOR:  cfg_reg.initiator     <= pwdata[0];
                    shre_pkg::REG_LOCAL_ID:   cfg_reg.local_conn_id <= pwdata;
                    shre_pkg::REG_MAX_RETRY:
                    begin
                        cfg_reg.max_retries  <= pwdata[2:0];
                        st_reg.attempts_left <= pwdata[2:0];
                    end
                    shre_pkg::REG_RETRY_BASE: cfg_reg.retry_base_ms <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // input and result stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            item_reg.command     <= evt.command;
            item_reg.now_ms      <= evt.now_ms;
            item_reg.msg_stamp   <= evt.msg_stamp;
            item_reg.msg_conn_id <= evt.msg_conn_id;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.send_kind        = res_reg.send_kind;
    assign res.send_conn_id     = res_reg.send_conn_id;
    assign res.send_stamp       = res_reg.send_stamp;
    assign res.retry_delay      = res_reg.retry_delay;
    assign res.cancel_retry     = res_reg.cancel_retry;
    assign res.heartbeat_delay  = res_reg.heartbeat_delay;
    assign res.cancel_heartbeat = res_reg.cancel_heartbeat;
    assign res.session_state    = res_reg.session_state;
    assign res.connected_event  = res_reg.connected_event;
    assign res.failed_event     = res_reg.failed_event;
    assign res.rtt_estimate     = res_reg.rtt_estimate;
    assign res.rtt_deviation    = res_reg.rtt_deviation;

endmodule

// ----- hdl/shre_step.sv -----
// ----------------------------------------------------------------------------
// Session engine event step
// Next state and result for one event, from the current state and config.
// ----------------------------------------------------------------------------
module shre_step (
    input  shre_pkg::cfg_t    cfg,
    input  shre_pkg::state_t  st,
    input  shre_pkg::item_t   item,
    output shre_pkg::state_t  st_next,
    output shre_pkg::result_t result
);

    logic        conn_fail;
    logic [2:0]  shift;
    logic [22:0] delay_wide;
    logic        sample_gt;
    logic [31:0] sample;
    logic [31:0] diff;
    logic [33:0] dev_sum;
    logic [34:0] rtt_sum;
    logic [31:0] dev_avg;
    logic [31:0] rtt_avg;

    // connect backoff: base doubled once per attempt already used
    always_comb
    begin
        conn_fail  = (st.attempts_left == 3'd0);
        shift      = (st.attempts_left <= cfg.max_retries) ?
                     (cfg.max_retries - st.attempts_left) : 3'd0;
        delay_wide = {7'd0, cfg.retry_base_ms} << shift;
    end

    // rtt sample and estimator update
    always_comb
    begin
        sample_gt = {1'b0, item.now_ms} > ({1'b0, item.msg_stamp} + 33'd5);
        sample    = sample_gt ? (item.now_ms - item.msg_stamp) : shre_pkg::SAMPLE_FLOOR;
        diff      = (st.smoothed_rtt > sample) ? (st.smoothed_rtt - sample)
                                               : (sample - st.smoothed_rtt);
        dev_sum   = {2'd0, st.smoothed_dev} + {1'b0, st.smoothed_dev, 1'b0} + {2'd0, diff};
        rtt_sum   = {st.smoothed_rtt, 3'd0} - {3'd0, st.smoothed_rtt} + {3'd0, sample};
        dev_avg   = dev_sum[33:2];
        rtt_avg   = rtt_sum[34:3];
    end

    always_comb
    begin
        st_next = st;
        result  = '0;
        result.send_kind = shre_pkg::SEND_NONE;

        unique case (shre_pkg::cmd_t'(item.command))
            shre_pkg::CMD_START,
            shre_pkg::CMD_RETRY_EXP:
            begin
                if ((item.command == shre_pkg::CMD_START && cfg.initiator) ||
                    (item.command == shre_pkg::CMD_RETRY_EXP &&
                     st.phase == shre_pkg::PH_CONNECTING))
                begin
                    if (conn_fail)
                    begin
                        result.failed_event     = 1'b1;
                        result.cancel_heartbeat = 1'b1;
                        if (cfg.initiator)
                        begin
                            result.send_kind    = shre_pkg::SEND_DISC;
                            result.send_conn_id = cfg.local_conn_id;
                            st_next.phase       = shre_pkg::PH_DISCONNECTED;
                        end
                    end
                    else
                    begin
                        result.retry_delay    = delay_wide[21:0];
                        result.send_kind      = shre_pkg::SEND_CONN;
                        result.send_conn_id   = cfg.local_conn_id;
                        st_next.attempts_left = st.attempts_left - 3'd1;
                        st_next.phase         = shre_pkg::PH_CONNECTING;
                    end
                end
            end
            shre_pkg::CMD_HBEAT_EXP:
            begin
                if (st.phase == shre_pkg::PH_CONNECTED)
                begin
                    result.heartbeat_delay = {st.smoothed_rtt, 2'b00};
                    result.send_kind       = shre_pkg::SEND_PING;
                    result.send_stamp      = item.now_ms;
                end
            end
            shre_pkg::CMD_STOP:
            begin
                result.cancel_heartbeat = 1'b1;
                if (cfg.initiator)
                begin
                    result.send_kind    = shre_pkg::SEND_DISC;
                    result.send_conn_id = cfg.local_conn_id;
                    st_next.phase       = shre_pkg::PH_DISCONNECTED;
                end
            end
            shre_pkg::CMD_RX_CONN:
            begin
                st_next.phase       = shre_pkg::PH_CONNECTED;
                result.send_kind    = shre_pkg::SEND_CONNACK;
                result.send_conn_id = item.msg_conn_id;
                if (!cfg.initiator && !st.peer_session_active)
                begin
                    st_next.peer_session_active = 1'b1;
                    result.heartbeat_delay      = {2'b00, st.smoothed_rtt};
                end
            end
            shre_pkg::CMD_RX_CONNACK:
            begin
                if (st.phase == shre_pkg::PH_CONNECTING)
                begin
                    st_next.phase          = shre_pkg::PH_CONNECTED;
                    result.connected_event = 1'b1;
                    result.cancel_retry    = 1'b1;
                    result.heartbeat_delay = {st.smoothed_rtt, 2'b00};
                    result.send_kind       = shre_pkg::SEND_PING;
                    result.send_stamp      = item.now_ms;
                end
            end
            shre_pkg::CMD_RX_PING:
            begin
                result.send_kind  = shre_pkg::SEND_PONG;
                result.send_stamp = item.msg_stamp;
            end
            shre_pkg::CMD_RX_PONG:
            begin
                if (st.awaiting_first_sample)
                begin
                    st_next.awaiting_first_sample = 1'b0;
                    st_next.smoothed_rtt          = sample;
                end
                else
                begin
                    st_next.smoothed_dev = (dev_avg < shre_pkg::EST_FLOOR) ?
                                           shre_pkg::EST_FLOOR : dev_avg;
                    st_next.smoothed_rtt = (rtt_avg < shre_pkg::EST_FLOOR) ?
                                           shre_pkg::EST_FLOOR : rtt_avg;
                end
            end
            shre_pkg::CMD_RX_DISC:
            begin
                st_next.phase               = shre_pkg::PH_DISCONNECTED;
                result.send_kind            = shre_pkg::SEND_DISCACK;
                result.send_conn_id         = item.msg_conn_id;
                st_next.peer_session_active = 1'b0;
            end
            shre_pkg::CMD_RX_DISCACK:
            begin
                st_next.phase = shre_pkg::PH_DISCONNECTED;
            end
            default:
            begin
            end
        endcase

        result.session_state = st_next.phase;
        result.rtt_estimate  = st_next.smoothed_rtt;
        result.rtt_deviation = st_next.smoothed_dev;
    end

endmodule

// ----- hdl/shre_checker.sv -----
// ----------------------------------------------------------------------------
// Session engine port checker
// Port-level checks on the session engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "session_handshake_rtt_engine_defines.svh"

module shre_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  send_kind,
    input logic [1:0]  session_state,
    input logic        connected_event,
    input logic        failed_event,
    input logic        cancel_heartbeat,
    input logic        cancel_retry,
    input logic [21:0] retry_delay,
    input logic        pready
);

    // a stalled result beat stays offered
    `SHRE_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)

    // handshake completion pings, cancels retry and reports connected
    `SHRE_ASSERT_IMP(a_connected, res_valid && connected_event, (session_state == shre_pkg::PH_CONNECTED) && (send_kind == shre_pkg::SEND_PING) && cancel_retry)

    // failure never arms a retry and always drops the heartbeat
    `SHRE_ASSERT_IMP(a_failed, res_valid && failed_event, (retry_delay == 22'd0) && cancel_heartbeat && !connected_event)

    // register port never inserts wait states
    `SHRE_ASSERT_IMP(a_pready, 1'b1, pready)

endmodule

bind session_handshake_rtt_engine shre_checker u_shre_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .send_kind        (res.send_kind),
    .session_state    (res.session_state),
    .connected_event  (res.connected_event),
    .failed_event     (res.failed_event),
    .cancel_heartbeat (res.cancel_heartbeat),
    .cancel_retry     (res.cancel_retry),
    .retry_delay      (res.retry_delay),
    .pready           (pready)
);
